@@ hdl/thrc_pkg.sv @@
// ----------------------------------------------------------------------------
// thrc_pkg: shared types and constants for the thermistor compensation block
// Payload structs, register indexes, the voltage table and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package thrc_pkg;

  localparam int ADC_W   = 10;
  localparam int MV_W    = 11;
  localparam int CFG_W   = 14;
  localparam int COEF_W  = 14;
  localparam int IDX_W   = 3;
  localparam int DIV_W   = 21;
  localparam int DVSR_W  = 10;
  localparam int QUOT_W  = 10;
  localparam int ROM_DEPTH = 166;

  localparam logic [DIV_W-1:0]  MV_SCALE  = 21'd1500;
  localparam logic [DVSR_W-1:0] MV_DIVSR  = 10'd1023;
  localparam logic [DVSR_W-1:0] COEF_DIVSR = 10'd1000;
  localparam logic signed [7:0] TEMP_RESET = 8'sd20;
  localparam logic signed [7:0] TEMP_COLD  = -8'sd40;
  localparam logic [7:0] ALERT_BASE = 8'd32;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_BASE_RCOMP   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_COEF_HOT     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_COEF_COLD    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_ALERT_THRESH = 3'd3;
  localparam logic [IDX_W-1:0] CFG_WIDE_MODE    = 3'd4;

  typedef struct packed {
    logic [ADC_W-1:0] adc_sample;
    logic             sample_valid;
  } in_t;

  typedef struct packed {
    logic signed [7:0] temperature_c;
    logic [7:0]        rcomp_value;
    logic [15:0]       config_word;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV_MV,
    ST_WAIT_MV,
    ST_SCAN,
    ST_WAIT_SCAN,
    ST_MUL,
    ST_DIV_COEF,
    ST_WAIT_COEF,
    ST_FINISH
  } state_e;

  // descending thermistor voltage table in millivolts, -40 C first
  localparam logic [MV_W-1:0] VOLT_ROM [0:ROM_DEPTH-1] = '{
    11'd1442, 11'd1439, 11'd1435, 11'd1432, 11'd1428, 11'd1424, 11'd1420, 11'd1416,
    11'd1412, 11'd1407, 11'd1402, 11'd1397, 11'd1392, 11'd1387, 11'd1381, 11'd1375,
    11'd1369, 11'd1363, 11'd1357, 11'd1350, 11'd1343, 11'd1336, 11'd1329, 11'd1321,
    11'd1313, 11'd1305, 11'd1297, 11'd1288, 11'd1279, 11'd1270, 11'd1261, 11'd1251,
    11'd1242, 11'd1232, 11'd1221, 11'd1211, 11'd1200, 11'd1189, 11'd1178, 11'd1167,
    11'd1156, 11'd1144, 11'd1132, 11'd1120, 11'd1108, 11'd1095, 11'd1083, 11'd1070,
    11'd1057, 11'd1044, 11'd1030, 11'd1017, 11'd1004, 11'd990,  11'd976,  11'd962,
    11'd949,  11'd935,  11'd921,  11'd907,  11'd893,  11'd878,  11'd864,  11'd850,
    11'd836,  11'd822,  11'd808,  11'd794,  11'd780,  11'd766,  11'd752,  11'd738,
    11'd724,  11'd711,  11'd697,  11'd684,  11'd671,  11'd658,  11'd645,  11'd632,
    11'd619,  11'd606,  11'd594,  11'd582,  11'd570,  11'd558,  11'd546,  11'd534,
    11'd523,  11'd512,  11'd501,  11'd490,  11'd479,  11'd469,  11'd458,  11'd448,
    11'd438,  11'd429,  11'd419,  11'd410,  11'd400,  11'd391,  11'd383,  11'd374,
    11'd365,  11'd357,  11'd349,  11'd341,  11'd333,  11'd326,  11'd318,  11'd311,
    11'd304,  11'd297,  11'd290,  11'd283,  11'd277,  11'd270,  11'd264,  11'd258,
    11'd252,  11'd246,  11'd241,  11'd235,  11'd230,  11'd224,  11'd219,  11'd214,
    11'd209,  11'd204,  11'd200,  11'd195,  11'd191,  11'd186,  11'd182,  11'd178,
    11'd174,  11'd170,  11'd166,  11'd162,  11'd159,  11'd155,  11'd152,  11'd148,
    11'd145,  11'd142,  11'd139,  11'd135,  11'd132,  11'd130,  11'd127,  11'd124,
    11'd121,  11'd119,  11'd116,  11'd114,  11'd111,  11'd109,  11'd106,  11'd104,
    11'd102,  11'd100,  11'd98,   11'd96,   11'd94,   11'd92
  };

  // entries past the populated part read as zero
  function automatic logic [MV_W-1:0] volt_rom_rd(input logic [7:0] idx);
    logic [MV_W-1:0] v;
    v = '0;
    if (int'(idx) < ROM_DEPTH) begin
      v = VOLT_ROM[idx];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/thermistor_rcomp_compensation.sv @@
// ----------------------------------------------------------------------------
// thermistor_rcomp_compensation: temperature compensated gauge word
// Converts a thermistor sample to degrees C and derives the compensation
// value and configuration word from it.
// ----------------------------------------------------------------------------
// Usage: a sample enters on the in channel (valid/ready) and one result leaves
// on the out channel (valid/ready). Registers are to be written through the
// plain cfg port only while the block is idle; the block itself does not
// enforce this. A valid sample passes through the scale, the millivolt divide,
// the table scan (one entry a cycle, ending at the first entry not above the
// voltage or at the last entry), the multiply, the coefficient divide and the
// finish step. An invalid sample goes from the scale step to the multiply.
// Throughput: one sample at a time; in_ready_o is high only while idle, so
// the next sample can be taken in the cycle after the result is loaded.
// The result sits in an output register, so the next sample can be taken
// while it still waits for the receiver.
// Reset: registers return to their defaults and the held temperature to 20 C.
// Stall: while the output register is full and not taken, a finished result
// waits in the last sequencer step and no new sample is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_rcomp_compensation #(
  parameter int TABLE_ENTRIES = 166
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire thrc_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output thrc_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [thrc_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [thrc_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int DW = thrc_pkg::DIV_W;

  thrc_pkg::state_e state_q, state_d;

  // configuration registers
  logic [7:0]                       base_q;
  logic signed [thrc_pkg::COEF_W-1:0] coef_hot_q;
  logic signed [thrc_pkg::COEF_W-1:0] coef_cold_q;
  logic [5:0]                       thresh_q;
  logic                             wide_q;

  logic [thrc_pkg::ADC_W-1:0] sample_q;
  logic                       svalid_q;
  logic signed [7:0]          temp_q;
  logic [DW-1:0]              dvd_q;
  logic [thrc_pkg::MV_W-1:0]  mv_q;
  logic [thrc_pkg::QUOT_W-1:0] quot_q;
  logic                       neg_q;
  logic                       out_valid_q;
  thrc_pkg::out_t             out_q;

  thrc_pkg::div_req_t div_req;
  thrc_pkg::div_rsp_t div_rsp;
  logic               scan_start;
  logic               scan_done;
  logic signed [7:0]  scan_temp;
  logic               out_free;

  logic signed [8:0]  diff;
  logic signed [thrc_pkg::COEF_W-1:0] coef_sel;
  logic signed [22:0] prod;
  logic [22:0]        mag;
  logic signed [11:0] sum;
  logic [7:0]         rcomp;
  logic [7:0]         thr8;
  logic [7:0]         alert;

  assign out_free = !out_valid_q || out_ready_i;

  // ------------------------------------------------------------ config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 8'd86;
      coef_hot_q  <= -14'sd1325;
      coef_cold_q <= -14'sd2925;
      thresh_q    <= 6'd4;
      wide_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        thrc_pkg::CFG_BASE_RCOMP:   base_q      <= cfg_data_i[7:0];
        thrc_pkg::CFG_COEF_HOT:     coef_hot_q  <= cfg_data_i;
        thrc_pkg::CFG_COEF_COLD:    coef_cold_q <= cfg_data_i;
        thrc_pkg::CFG_ALERT_THRESH: thresh_q    <= cfg_data_i[5:0];
        thrc_pkg::CFG_WIDE_MODE:    wide_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thrc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      thrc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = thrc_pkg::ST_SCALE;
        end
      end
      thrc_pkg::ST_SCALE: begin
        state_d = svalid_q ? thrc_pkg::ST_DIV_MV : thrc_pkg::ST_MUL;
      end
      thrc_pkg::ST_DIV_MV:  state_d = thrc_pkg::ST_WAIT_MV;
      thrc_pkg::ST_WAIT_MV: begin
        if (div_rsp.done) begin
          state_d = thrc_pkg::ST_SCAN;
        end
      end
      thrc_pkg::ST_SCAN:      state_d = thrc_pkg::ST_WAIT_SCAN;
      thrc_pkg::ST_WAIT_SCAN: begin
        if (scan_done) begin
          state_d = thrc_pkg::ST_MUL;
        end
      end
      thrc_pkg::ST_MUL:       state_d = thrc_pkg::ST_DIV_COEF;
      thrc_pkg::ST_DIV_COEF:  state_d = thrc_pkg::ST_WAIT_COEF;
      thrc_pkg::ST_WAIT_COEF: begin
        if (div_rsp.done) begin
          state_d = thrc_pkg::ST_FINISH;
        end
      end
      thrc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = thrc_pkg::ST_IDLE;
        end
      end
      default: state_d = thrc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    scan_start       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = dvd_q;
    div_req.divisor  = thrc_pkg::MV_DIVSR;
    case (state_q)
      thrc_pkg::ST_IDLE:     in_ready_o = 1'b1;
      thrc_pkg::ST_DIV_MV:   div_req.start = 1'b1;
      thrc_pkg::ST_SCAN:     scan_start = 1'b1;
      thrc_pkg::ST_DIV_COEF: begin
        div_req.start   = 1'b1;
        div_req.divisor = thrc_pkg::COEF_DIVSR;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ datapath
  assign diff     = 9'(temp_q) - 9'sd20;
  assign coef_sel = (temp_q > thrc_pkg::TEMP_RESET) ? coef_hot_q : coef_cold_q;
  assign prod     = 23'(diff) * 23'(coef_sel);
  assign mag      = prod[22] ? 23'(-prod) : 23'(prod);

  // base plus or minus the truncated quotient, then clamp to a byte
  assign sum   = $signed({4'b0, base_q})
               + (neg_q ? -$signed({2'b0, quot_q}) : $signed({2'b0, quot_q}));
  assign rcomp = sum[11] ? 8'd0 : ((|sum[10:8]) ? 8'hFF : sum[7:0]);
  assign thr8  = wide_q ? {1'b0, thresh_q, 1'b0} : {2'b0, thresh_q};
  assign alert = thrc_pkg::ALERT_BASE - thr8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= thrc_pkg::TEMP_RESET;
    end else if (state_q == thrc_pkg::ST_WAIT_SCAN && scan_done) begin
      temp_q <= scan_temp;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      thrc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          sample_q <= in_data_i.adc_sample;
          svalid_q <= in_data_i.sample_valid;
        end
      end
      thrc_pkg::ST_SCALE: dvd_q <= DW'(sample_q) * thrc_pkg::MV_SCALE;
      thrc_pkg::ST_WAIT_MV: begin
        if (div_rsp.done) begin
          mv_q <= div_rsp.quotient[thrc_pkg::MV_W-1:0];
        end
      end
      thrc_pkg::ST_MUL: begin
        dvd_q <= mag[DW-1:0];
        neg_q <= prod[22];
      end
      thrc_pkg::ST_WAIT_COEF: begin
        if (div_rsp.done) begin
          quot_q <= div_rsp.quotient[thrc_pkg::QUOT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == thrc_pkg::ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == thrc_pkg::ST_FINISH && out_free) begin
      out_q.temperature_c <= temp_q;
      out_q.rcomp_value   <= rcomp;
      out_q.config_word   <= {rcomp, alert};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------ units
  thrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  thrc_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .mv_i    (mv_q),
    .done_o  (scan_done),
    .temp_o  (scan_temp)
  );

endmodule

`default_nettype wire

@@ hdl/thrc_div.sv @@
// ----------------------------------------------------------------------------
// thrc_div: shared constant divider
// Quotient of a 21-bit dividend by 1023 or 1000 through a reciprocal
// multiply, operands registered on start and the quotient in the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module thrc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire thrc_pkg::div_req_t req_i,
  output thrc_pkg::div_rsp_t      rsp_o
);

  localparam int DW = thrc_pkg::DIV_W;
  localparam int PW = 43;
  // ceil(2^31 / 1023) and ceil(2^30 / 1000), exact over the dividend range
  localparam logic [21:0] REC_MV   = 22'd2099203;
  localparam logic [21:0] REC_COEF = 22'd1073742;

  logic          busy_q;
  logic          done_q;
  logic [DW-1:0] dvd_q;
  logic          sel_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [21:0]   recip;
  logic [PW-1:0] prod;

  assign recip = sel_q ? REC_COEF : REC_MV;
  assign prod  = PW'(dvd_q) * PW'(recip);
  assign quo_d = sel_q ? {8'b0, prod[42:30]} : {9'b0, prod[42:31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= req_i.start;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      sel_q <= (req_i.divisor == thrc_pkg::COEF_DIVSR);
    end
    if (busy_q) begin
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

@@ hdl/thrc_scan.sv @@
// ----------------------------------------------------------------------------
// thrc_scan: voltage table scan
// Walks the descending table one entry a cycle and converts the hit count
// into degrees C.
// ----------------------------------------------------------------------------
`default_nettype none

module thrc_scan #(
  parameter int TABLE_ENTRIES = 166
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [thrc_pkg::MV_W-1:0]   mv_i,
  output logic                             done_o,
  output logic signed [7:0]                temp_o
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int NW  = $clog2(TABLE_ENTRIES + 1);
  localparam int TW  = 10;

  logic                     busy_q;
  logic                     done_q;
  logic [IW-1:0]            idx_q;
  logic [NW-1:0]            cnt_q;
  logic [thrc_pkg::MV_W-1:0] mv_q;
  logic                     hit;
  logic                     last;
  logic [TW-1:0]            cnt_ext;
  logic [TW-1:0]            temp_raw;

  assign hit  = mv_q < thrc_pkg::volt_rom_rd(8'(idx_q));
  assign last = idx_q == IW'(TABLE_ENTRIES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (hit) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (!hit || last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mv_q <= mv_i;
    end
  end

  // at or above the top entry reads as the coldest point
  assign cnt_ext  = TW'(cnt_q);
  assign temp_raw = cnt_ext - TW'(41);
  assign temp_o   = (cnt_q == '0) ? thrc_pkg::TEMP_COLD : temp_raw[7:0];
  assign done_o   = done_q;

endmodule

`default_nettype wire
